>>> rtl/kph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kph_pkg
// Shared types and constants of the Mersenne-61 polynomial hash core.
// ----------------------------------------------------------------------------
package kph_pkg;

    localparam int PRIME_W    = 61;
    localparam int HASH_W     = 3;
    localparam int COEF_W     = 3;
    localparam int MAX_HASHES = 8;
    localparam int MAX_COEFS  = 8;
    localparam int ADDR_W     = HASH_W + COEF_W;
    localparam int TBL_DEPTH  = MAX_HASHES * MAX_COEFS;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = 6;
    localparam int VALUE_W    = 62;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_DATA_W = 61;

    localparam logic [PRIME_W-1:0] PRIME = '1;
    localparam logic [STEP_W-1:0]  MUL_LAST = STEP_W'(4);
    localparam logic [STEP_W-1:0]  DIV_LAST = STEP_W'(PRIME_W - 1);

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_SIGN  = 2'd1,
        MODE_BIN   = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_BINS   = 2'd1,
        CFG_ACTIVE = 2'd2,
        CFG_INDEP  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_HASH  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_ACC0,
        ST_MUL,
        ST_SUM,
        ST_FOLD,
        ST_SUB,
        ST_POST,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              ld_key;
        logic              ld_acc0;
        logic              pp_go;
        logic [1:0]        pp_sel;
        logic              prod_clr;
        logic              prod_add;
        logic              sum_go;
        logic              fold_go;
        logic              sub_go;
        logic              div_start;
        logic              div_step;
        logic              out_load;
        logic              out_last;
        logic [HASH_W-1:0] out_index;
        logic [ADDR_W-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] m_eff;
        logic [CNT_W-1:0] k_eff;
        logic             div_need;
        logic             out_free;
    } t_status;

endpackage

>>> rtl/kwise_poly_hash_mersenne61_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwise_poly_hash_mersenne61_core
// k-wise independent polynomial hash modulo 2^61-1, up to eight functions.
//
// Input stream: tuser = opcode (0 write coefficient, 1 hash key). tdata from
// bit 0: hash_select[2:0], coef_select[5:3], coef_value[66:6], key[127:67].
// A write beat is absorbed and yields nothing. A hash beat yields one output
// beat per active function, in index order, tlast on the final one. Output
// tdata[61:0] is the signed value, tuser the index.
// Configuration: i_cfg_we writes register i_cfg_addr (mode, bin count,
// active functions, independence); the user must write it only while the
// core is idle, as the core does not enforce this. Per function: Horner
// steps on one 31x31 multiplier (four partial products per step), then
// bit-serial division in bin mode with a nonzero bin count, then a load of
// the output register. The input is ready only between keys; the output
// register holds a beat while m_axis_tready is low and stalls the sequence
// only when the next beat is due. Reset clears the configuration to
// defaults and drops any beat.
// ----------------------------------------------------------------------------
module kwise_poly_hash_mersenne61_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_addr,
    input  logic [kph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // hash_select, coef_select, coef_value, key
    input  logic [kph_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // hash_value, zero pad
    output logic [kph_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // hash_index
    output logic [kph_pkg::HASH_W-1:0]     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import kph_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign s_axis_tready = w_in_ready;

    kph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    kph_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (s_axis_tvalid && w_in_ready),
        .i_in_op     (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_index (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );
endmodule

>>> rtl/kph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/kph_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kph_dp
// Datapath: configuration, coefficient table, multiply-fold unit, bin
// divider and output register.
// ----------------------------------------------------------------------------
module kph_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [kph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_accept,
    input  logic                          i_in_op,
    input  logic [kph_pkg::IN_DATA_W-1:0] i_in_data,
    input  kph_pkg::t_cmd                 i_cmd,
    output kph_pkg::t_status              o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [kph_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic [kph_pkg::HASH_W-1:0]    o_out_index,
    output logic                          o_out_last
);
    import kph_pkg::*;

    logic [1:0]         r_mode;
    logic [PRIME_W-1:0] r_bins;
    logic [3:0]         r_active;
    logic [3:0]         r_indep;

    logic [HASH_W-1:0]  w_hsel;
    logic [COEF_W-1:0]  w_csel;
    logic [PRIME_W-1:0] w_coef_raw;
    logic [PRIME_W-1:0] w_key_raw;
    logic [PRIME_W-1:0] w_coef;
    logic [PRIME_W-1:0] w_rdata;
    logic               w_we;

    logic [PRIME_W-1:0]     r_key;
    logic [PRIME_W-1:0]     r_acc;
    logic [VALUE_W-1:0]     r_pp;
    logic [1:0]             r_pp_sel;
    logic [2*PRIME_W-1:0]   r_prod;
    logic [2*PRIME_W-1:0]   r_sum;
    logic [PRIME_W:0]       r_fold;
    logic [PRIME_W-1:0]     r_dvd;
    logic [PRIME_W-1:0]     r_rem;

    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_value;
    logic [HASH_W-1:0]      r_out_index;
    logic                   r_out_last;

    logic [30:0]            w_pa;
    logic [30:0]            w_pb;
    logic [2*PRIME_W-1:0]   w_addend;
    logic [PRIME_W:0]       w_trial;
    logic [VALUE_W-1:0]     w_value;

    assign w_hsel     = i_in_data[2:0];
    assign w_csel     = i_in_data[5:3];
    assign w_coef_raw = i_in_data[66:6];
    assign w_key_raw  = i_in_data[127:67];
    assign w_coef     = (w_coef_raw == PRIME) ? '0 : w_coef_raw;
    assign w_we       = i_in_accept && (i_in_op == OP_WRITE);

    kph_ram #(
        .WIDTH (PRIME_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({w_hsel, w_csel}),
        .i_wdata (w_coef),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RAW;
            r_bins   <= PRIME_W'(1);
            r_active <= 4'd1;
            r_indep  <= 4'd2;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_BINS:   r_bins   <= i_cfg_data;
                CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                CFG_INDEP:  r_indep  <= i_cfg_data[3:0];
            endcase
        end
    end

    always_comb begin
        o_status.m_eff = (r_active > CNT_W'(MAX_HASHES)) ? CNT_W'(MAX_HASHES) : r_active;
        priority if (r_indep == '0) begin
            o_status.k_eff = CNT_W'(1);
        end else if (r_indep > CNT_W'(MAX_COEFS)) begin
            o_status.k_eff = CNT_W'(MAX_COEFS);
        end else begin
            o_status.k_eff = r_indep;
        end
        o_status.div_need = (r_mode == MODE_BIN) && (r_bins != '0);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign w_pa = i_cmd.pp_sel[1] ? {1'b0, r_acc[60:31]} : r_acc[30:0];
    assign w_pb = i_cmd.pp_sel[0] ? {1'b0, r_key[60:31]} : r_key[30:0];

    always_comb begin
        unique case (r_pp_sel)
            2'd0:    w_addend = (2*PRIME_W)'(r_pp);
            2'd3:    w_addend = (2*PRIME_W)'(r_pp) << 62;
            default: w_addend = (2*PRIME_W)'(r_pp) << 31;
        endcase
    end

    assign w_trial = {r_rem, r_dvd[PRIME_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_key) begin
            r_key <= (w_key_raw == PRIME) ? '0 : w_key_raw;
        end
        if (i_cmd.pp_go) begin
            r_pp     <= VALUE_W'(w_pa) * VALUE_W'(w_pb);
            r_pp_sel <= i_cmd.pp_sel;
        end
        if (i_cmd.prod_clr) begin
            r_prod <= '0;
        end else if (i_cmd.prod_add) begin
            r_prod <= r_prod + w_addend;
        end
        if (i_cmd.sum_go) begin
            r_sum <= r_prod + (2*PRIME_W)'(w_rdata);
        end
        if (i_cmd.fold_go) begin
            r_fold <= {1'b0, r_sum[PRIME_W-1:0]} + {1'b0, r_sum[2*PRIME_W-1:PRIME_W]};
        end
        if (i_cmd.ld_acc0) begin
            r_acc <= w_rdata;
        end else if (i_cmd.sub_go) begin
            r_acc <= (r_fold >= {1'b0, PRIME}) ? PRIME_W'(r_fold - {1'b0, PRIME})
                                               : r_fold[PRIME_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_dvd <= r_acc;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= (w_trial >= {1'b0, r_bins}) ? PRIME_W'(w_trial - {1'b0, r_bins})
                                                 : w_trial[PRIME_W-1:0];
        end
    end

    always_comb begin
        priority if (r_mode == MODE_SIGN) begin
            w_value = r_acc[0] ? VALUE_W'(1) : '1;
        end else if (o_status.div_need) begin
            w_value = VALUE_W'(r_rem);
        end else begin
            w_value = VALUE_W'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= w_value;
            r_out_index <= i_cmd.out_index;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_DATA_W'(r_out_value);
    assign o_out_index = r_out_index;
    assign o_out_last  = r_out_last;
endmodule

>>> rtl/kph_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kph_ctrl
// Controller: sequences Horner steps, bin division and result beats.
// ----------------------------------------------------------------------------
module kph_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    input  kph_pkg::t_status i_status,
    output kph_pkg::t_cmd    o_cmd
);
    import kph_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_h;
    logic [CNT_W-1:0]   r_i;
    logic [STEP_W-1:0]  r_cnt;
    logic               w_accept;
    logic               w_more_coef;
    logic               w_more_hash;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_more_coef = (r_i + CNT_W'(1)) < i_status.k_eff;
    assign w_more_hash = (r_h + CNT_W'(1)) < i_status.m_eff;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_op == OP_HASH) && (i_status.m_eff != '0)) begin
                    n_state = ST_RD0;
                end
            end
            ST_RD0:  n_state = ST_ACC0;
            ST_ACC0: n_state = (i_status.k_eff == CNT_W'(1)) ? ST_POST : ST_MUL;
            ST_MUL:  n_state = (r_cnt == MUL_LAST) ? ST_SUM : ST_MUL;
            ST_SUM:  n_state = ST_FOLD;
            ST_FOLD: n_state = ST_SUB;
            ST_SUB:  n_state = w_more_coef ? ST_MUL : ST_POST;
            ST_POST: n_state = i_status.div_need ? ST_DIV : ST_OUT;
            ST_DIV:  n_state = (r_cnt == DIV_LAST) ? ST_OUT : ST_DIV;
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = w_more_hash ? ST_RD0 : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.rd_addr   = {r_h[HASH_W-1:0], r_i[COEF_W-1:0]};
        o_cmd.out_index = r_h[HASH_W-1:0];
        o_cmd.out_last  = !w_more_hash;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_key = w_accept && (i_in_op == OP_HASH);
            end
            ST_ACC0: o_cmd.ld_acc0 = 1'b1;
            ST_MUL: begin
                o_cmd.pp_go    = (r_cnt != MUL_LAST);
                o_cmd.pp_sel   = r_cnt[1:0];
                o_cmd.prod_clr = (r_cnt == '0);
                o_cmd.prod_add = (r_cnt != '0);
            end
            ST_SUM:  o_cmd.sum_go    = 1'b1;
            ST_FOLD: o_cmd.fold_go   = 1'b1;
            ST_SUB:  o_cmd.sub_go    = 1'b1;
            ST_POST: o_cmd.div_start = i_status.div_need;
            ST_DIV:  o_cmd.div_step  = 1'b1;
            ST_OUT:  o_cmd.out_load  = i_status.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h     <= '0;
            r_i     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_h <= '0;
                    r_i <= '0;
                end
                ST_ACC0: begin
                    r_i   <= CNT_W'(1);
                    r_cnt <= '0;
                end
                ST_MUL, ST_DIV: r_cnt <= r_cnt + STEP_W'(1);
                ST_SUB: begin
                    r_i   <= r_i + CNT_W'(1);
                    r_cnt <= '0;
                end
                ST_POST: r_cnt <= '0;
                ST_OUT: begin
                    if (i_status.out_free) begin
                        r_h <= r_h + CNT_W'(1);
                        r_i <= '0;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> rtl/kph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kph_checker
// Port-level assertions on the hash core, bound to the top level.
// ----------------------------------------------------------------------------
module kph_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [kph_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import kph_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:VALUE_W] == '0)
        else $error("output padding not zero");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("coefficient write produced a beat");
endmodule

bind kwise_poly_hash_mersenne61_core kph_checker u_kph_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/kwise_poly_hash_mersenne61_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwise_poly_hash_mersenne61_core_tb
// Self-checking bench for the Mersenne-61 polynomial hash core.
//
// Fills the whole coefficient table, walks a short table of directed beats
// (extreme coefficients and keys, values equal to the prime), then runs
// phases of random writes and keys under a range of mode, bin count, active
// function and independence settings. Each output beat is compared with a
// Horner's-rule model of the core kept in the bench, or a directed row's value.
// Both stream sides stall in random bursts except in phases 2, 6, 10, 12, 13.
// ----------------------------------------------------------------------------
module kwise_poly_hash_mersenne61_core_tb;
    import kph_pkg::*;

    localparam int                 LIMIT   = 4000000;
    localparam int                 SETTLE  = 1200;
    localparam int                 PHASES  = 14;
    localparam int                 PER_PH  = 22;
    localparam logic [PRIME_W-1:0] PM1     = PRIME - 1'b1;

    typedef struct {
        logic [HASH_W-1:0]  idx;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_hash_beat;

    typedef struct {
        t_op                op;
        logic [2:0]         hs;
        logic [2:0]         cs;
        logic [PRIME_W-1:0] cv;
        logic [PRIME_W-1:0] key;
        logic               typed;
        logic [VALUE_W-1:0] value;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [HASH_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    logic [PRIME_W-1:0] coefs [TBL_DEPTH];
    logic [1:0]         mode_q = MODE_RAW;
    logic [PRIME_W-1:0] bins_q = 1;
    logic [3:0]         active_q = 1;
    logic [3:0]         indep_q = 2;

    t_hash_beat hash_q[$];
    int         errors = 0;
    int         mismatches = 0;
    int         cycles = 0;
    bit         idle_en = 1'b1;

    kwise_poly_hash_mersenne61_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [PRIME_W-1:0] reduce61(logic [PRIME_W-1:0] v);
        return (v == PRIME) ? '0 : v;
    endfunction

    function automatic logic [PRIME_W-1:0] horner(int h, logic [PRIME_W-1:0] x, int k);
        logic [121:0]       p;
        logic [PRIME_W:0]   f;
        logic [PRIME_W-1:0] acc;
        acc = coefs[h*MAX_COEFS];
        for (int i = 1; i < k; i++) begin
            p = 122'(acc) * 122'(x) + 122'(coefs[h*MAX_COEFS+i]);
            f = {1'b0, p[60:0]} + {1'b0, p[121:61]};
            acc = (f >= {1'b0, PRIME}) ? PRIME_W'(f - {1'b0, PRIME}) : f[PRIME_W-1:0];
        end
        return acc;
    endfunction

    task automatic predict(t_op op, logic [2:0] hs, logic [2:0] cs,
                           logic [PRIME_W-1:0] cv, logic [PRIME_W-1:0] key);
        int                 m;
        int                 k;
        logic [PRIME_W-1:0] h;
        t_hash_beat         b;
        if (op == OP_WRITE) begin
            coefs[hs*MAX_COEFS+cs] = reduce61(cv);
            return;
        end
        m = (active_q > MAX_HASHES) ? MAX_HASHES : active_q;
        k = (indep_q == 0) ? 1 : ((indep_q > MAX_COEFS) ? MAX_COEFS : indep_q);
        for (int j = 0; j < m; j++) begin
            h = horner(j, reduce61(key), k);
            b.idx = HASH_W'(j);
            b.last = (j == m - 1);
            if (mode_q == MODE_SIGN)
                b.value = h[0] ? VALUE_W'(1) : '1;
            else if (mode_q == MODE_BIN && bins_q != 0)
                b.value = VALUE_W'(h % bins_q);
            else
                b.value = VALUE_W'(h);
            hash_q.push_back(b);
        end
    endtask

    task automatic send(t_op op, logic [2:0] hs, logic [2:0] cs,
                        logic [PRIME_W-1:0] cv, logic [PRIME_W-1:0] key, bit own);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tdata = {key, cv, cs, hs};
        s_axis_tuser = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (own)
            predict(op, hs, cs, cv, key);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (hash_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx a, logic [CFG_DATA_W-1:0] d);
        i_cfg_we = 1'b1;
        i_cfg_addr = a;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(logic [1:0] md, logic [PRIME_W-1:0] bn, logic [3:0] ac,
                             logic [3:0] ik);
        cfg_write(CFG_MODE, CFG_DATA_W'(md));
        cfg_write(CFG_BINS, bn);
        cfg_write(CFG_ACTIVE, CFG_DATA_W'(ac));
        cfg_write(CFG_INDEP, CFG_DATA_W'(ik));
        mode_q = md;
        bins_q = bn;
        active_q = ac;
        indep_q = ik;
    endtask

    function automatic logic [PRIME_W-1:0] rnd61();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PM1;
            2: return PRIME;
            3: return PRIME_W'($urandom_range(0, 15));
            default: return PRIME_W'({$urandom, $urandom});
        endcase
    endfunction

    // receiver stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_hash_beat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hash_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected beat: idx %0d value %h last %b",
                             m_axis_tuser, m_axis_tdata[VALUE_W-1:0], m_axis_tlast);
            end else begin
                e = hash_q.pop_front();
                if (m_axis_tuser !== e.idx || m_axis_tdata !== OUT_DATA_W'(e.value)
                        || m_axis_tlast !== e.last) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp idx %0d value %h last %b, got %0d %h %b",
                                 e.idx, e.value, e.last, m_axis_tuser, m_axis_tdata,
                                 m_axis_tlast);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_op  op;
        logic [1:0]         md;
        logic [PRIME_W-1:0] bn;

        rows = '{
            '{OP_WRITE, 3'd0, 3'd0, '0,    '0, 1'b0, '0},
            '{OP_WRITE, 3'd0, 3'd1, PM1,   '0, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    '0, 1'b1, VALUE_W'(PM1)},
            '{OP_HASH,  3'd7, 3'd7, '0,    PM1, 1'b1, VALUE_W'(PM1)},
            '{OP_WRITE, 3'd0, 3'd0, PRIME, '0, 1'b0, '0},
            '{OP_WRITE, 3'd0, 3'd1, PRIME, '0, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    61'd123, 1'b1, '0},
            '{OP_WRITE, 3'd7, 3'd7, PRIME, '0, 1'b0, '0},
            '{OP_WRITE, 3'd0, 3'd0, 61'd1, '0, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    PRIME, 1'b1, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    PM1, 1'b1, VALUE_W'(PM1)},
            '{OP_HASH,  3'd0, 3'd0, '0,    61'd5, 1'b1, VALUE_W'(5)},
            '{OP_WRITE, 3'd0, 3'd0, PM1,   '0, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    61'd1, 1'b1, VALUE_W'(PM1)},
            '{OP_HASH,  3'd0, 3'd0, '0,    PM1, 1'b1, VALUE_W'(1)},
            '{OP_WRITE, 3'd0, 3'd1, PM1,   '0, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    61'd1, 1'b1, VALUE_W'(PM1 - 1'b1)},
            '{OP_HASH,  3'd0, 3'd0, '0,    PRIME, 1'b1, VALUE_W'(PM1)},
            '{OP_WRITE, 3'd0, 3'd0, 61'h0AAA_AAAA_AAAA_AAAA, '0, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    61'h1555_5555_5555_5555, 1'b0, '0},
            '{OP_HASH,  3'd0, 3'd0, '0,    PM1 - 1'b1, 1'b0, '0}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every entry so no hash reads an unwritten coefficient
        for (int i = 0; i < TBL_DEPTH; i++)
            send(OP_WRITE, 3'(i / MAX_COEFS), 3'(i % MAX_COEFS), rnd61(), rnd61(), 1'b1);

        foreach (rows[i]) begin
            r = rows[i];
            if (r.typed) begin
                send(r.op, r.hs, r.cs, r.cv, r.key, 1'b0);
                hash_q.push_back('{HASH_W'(0), r.value, 1'b1});
            end else begin
                send(r.op, r.hs, r.cs, r.cv, r.key, 1'b1);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            idle_en = (p % 4 != 2) && (p < PHASES - 2);
            case (p)
                0: configure(MODE_RAW, 1, 8, 8);
                1: configure(MODE_SIGN, 1, 0, 1);
                2: configure(MODE_BIN, PRIME, 8, 0);
                3: configure(MODE_BIN, 0, 15, 15);
                4: configure(MODE_SPARE, 1, 9, 1);
                5: configure(MODE_BIN, 64, 3, 3);
                6: configure(MODE_BIN, 1, 2, 2);
                7: configure(MODE_SIGN, 5, 4, 8);
                default: begin
                    md = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: bn = PRIME_W'($urandom_range(1, 100));
                        1: bn = PRIME_W'(1) << $urandom_range(0, 60);
                        default: bn = PRIME_W'({$urandom, $urandom});
                    endcase
                    configure(md, bn, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                end
            endcase
            for (int n = 0; n < PER_PH; n++) begin
                if (p == 3 && n == PER_PH / 2) begin
                    s_axis_tvalid = 1'b0;
                    while (hash_q.size() != 0) @(negedge i_clk);
                end
                op = ($urandom_range(0, 9) < 7) ? OP_HASH : OP_WRITE;
                send(op, 3'($urandom), 3'($urandom), rnd61(), rnd61(), 1'b1);
            end
        end

        wait_idle();
        if (errors == 0 && hash_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
